// ===== src/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros for the checker of the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define SBH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hasher port check failed");

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define SBH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hasher port check failed");

`endif

// ===== src/sha256bs_pkg.sv =====
// Shared types and constants of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sha256bs_pkg;

  // Request codes.
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Block geometry and padding.
  localparam int BLOCK_BYTES = 64;
  localparam int FILL_W = $clog2(BLOCK_BYTES);
  localparam logic [FILL_W-1:0] LEN_OFFSET = 6'd56;
  localparam logic [FILL_W-1:0] LAST_BYTE = 6'd63;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Compression rounds.
  localparam int ROUNDS = 64;
  localparam int ROUND_W = $clog2(ROUNDS);
  localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;

  // Digest word positions.
  localparam int WORD_IDX_W = 3;
  localparam logic [WORD_IDX_W-1:0] FIRST_WORD_IDX = 3'd0;
  localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = 3'd7;

  // Eight hash words, index 0 is the most significant word of the digest.
  typedef logic [0:7][31:0] hash_t;

  localparam hash_t INITIAL_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Request word.
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  // Response word.
  typedef struct packed {
    logic [31:0]           digest_word;
    logic [WORD_IDX_W-1:0] word_index;
    logic                  last_word;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_BLOCK,
    S_PAD_A,
    S_RESTART,
    S_PAD_B,
    S_EMIT
  } state_t;

  // How the block buffer is shaped into message words for one compression.
  typedef enum logic [1:0] {
    PAD_NONE,
    PAD_OPEN,
    PAD_CLOSE,
    PAD_LEN
  } pad_t;

  // Control from the sequencer to the compression engine.
  typedef struct packed {
    logic start;
  } core_ctl_t;

  // Status from the compression engine.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ROUND_W-1:0] round;
  } core_stat_t;

endpackage

// ===== src/sha256bs_core.sv =====
// Iterative SHA-256 compression engine: one round per cycle with a rolling schedule.
`timescale 1ns / 1ps

module sha256bs_core (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256bs_pkg::core_ctl_t ctl,
  input  sha256bs_pkg::hash_t     hash_in,
  input  logic [31:0]             msg_word,
  output sha256bs_pkg::core_stat_t stat,
  output sha256bs_pkg::hash_t     hash_sum
);

  localparam logic [0:sha256bs_pkg::ROUNDS-1][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic                            busy;
  logic                            fin;
  logic [sha256bs_pkg::ROUND_W-1:0] round;
  sha256bs_pkg::hash_t             v;
  sha256bs_pkg::hash_t             v_next;
  logic [0:15][31:0]               win;
  logic [0:15][31:0]               win_next;
  logic [31:0]                     wt;
  logic [31:0]                     t1;
  logic [31:0]                     t2;
  logic [31:0]                     choose;
  logic [31:0]                     major;

  // Round word: buffer words for the first sixteen rounds, then the schedule.
  always_comb begin
    if (round[sha256bs_pkg::ROUND_W-1:4] == 2'b00) begin
      wt = msg_word;
    end else begin
      wt = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    end
    win_next = {win[1:15], wt};
  end

  // One compression round on the working variables.
  always_comb begin
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_sigma1(v[4]) + choose + ROUND_K[round] + wt;
    t2     = big_sigma0(v[0]) + major;
    v_next = {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
  end

  // Feed-forward of the chaining value.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_sum[i] = hash_in[i] + v[i];
    end
  end

  // Round sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      round <= '0;
    end else begin
      fin <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 1'b1;
        if (round == sha256bs_pkg::LAST_ROUND) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v <= hash_in;
    end else if (busy) begin
      v   <= v_next;
      win <= win_next;
    end
  end

  assign stat.busy  = busy;
  assign stat.done  = fin;
  assign stat.round = round;

endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: buffer, padding and sequencer.
//
// Usage: each request word carries one message byte (req_type append) or a
// finish command. Responses carry the eight 32-bit digest words, index 0
// (most significant) first, with last_word set on index 7.
// Flow: a byte that does not fill the 64-byte block leaves req_ready high.
// The 64th byte starts the compression engine, which runs one round per
// cycle; req_ready returns once its done pulse has brought the sequencer
// back to idle. A finish pads in place and compresses once or, with more
// than 55 bytes buffered, twice before the first digest word is offered.
// No byte is taken while a block is compressed; the pace is set by the
// single round unit that all 64 rounds of a block share.
// Stalls: while digest words are offered no request is taken; each word
// holds until rsp_ready, and the next follows in the following cycle.
// After the last word the hash and bit count return to their initial
// values, so the next byte starts a new message.
// Reset: synchronous rst loads the initial hash and a zero bit count; the
// block comes out of reset ready to take a byte.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sha256bs_pkg::req_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sha256bs_pkg::rsp_t rsp
);

  sha256bs_pkg::state_t              state;
  sha256bs_pkg::state_t              state_next;
  sha256bs_pkg::pad_t                pad;
  sha256bs_pkg::hash_t               hash;
  sha256bs_pkg::hash_t               hash_sum;
  sha256bs_pkg::core_ctl_t           core_ctl;
  sha256bs_pkg::core_stat_t          core_stat;
  logic [63:0]                       bit_count;
  logic [0:15][31:0]                 buf_words;
  logic [sha256bs_pkg::FILL_W-1:0]   fill;
  logic [sha256bs_pkg::WORD_IDX_W-1:0] out_idx;
  logic [31:0]                       msg_word;
  logic                              req_take;
  logic                              rsp_take;
  logic                              long_pad;

  assign fill     = bit_count[8:3];
  assign req_take = req_valid && req_ready;
  assign rsp_take = rsp_valid && rsp_ready;
  assign long_pad = (fill >= sha256bs_pkg::LEN_OFFSET);

  // Message word for the current round, shaped by the padding mode.
  always_comb begin : word_shape
    logic [31:0] raw;
    logic [5:0]  pos;
    logic [7:0]  rb;
    raw = buf_words[core_stat.round[3:0]];
    for (int k = 0; k < 4; k++) begin
      pos = {core_stat.round[3:0], 2'(k)};
      rb  = raw[8*(3-k) +: 8];
      unique case (pad) inside
        sha256bs_pkg::PAD_NONE: begin
          msg_word[8*(3-k) +: 8] = rb;
        end
        sha256bs_pkg::PAD_OPEN, sha256bs_pkg::PAD_CLOSE: begin
          if (pos < fill) begin
            msg_word[8*(3-k) +: 8] = rb;
          end else if (pos == fill) begin
            msg_word[8*(3-k) +: 8] = sha256bs_pkg::PAD_BYTE;
          end else begin
            msg_word[8*(3-k) +: 8] = 8'h00;
          end
        end
        default: begin
          msg_word[8*(3-k) +: 8] = 8'h00;
        end
      endcase
    end
    // The last two words of a closing block carry the big-endian bit length.
    if (pad == sha256bs_pkg::PAD_CLOSE || pad == sha256bs_pkg::PAD_LEN) begin
      if (core_stat.round[3:0] == 4'd14) begin
        msg_word = bit_count[63:32];
      end else if (core_stat.round[3:0] == 4'd15) begin
        msg_word = bit_count[31:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sha256bs_pkg::S_IDLE: begin
        if (req_take) begin
          if (req.req_type == sha256bs_pkg::REQ_FINISH) begin
            state_next = long_pad ? sha256bs_pkg::S_PAD_A : sha256bs_pkg::S_PAD_B;
          end else if (fill == sha256bs_pkg::LAST_BYTE) begin
            state_next = sha256bs_pkg::S_BLOCK;
          end
        end
      end
      sha256bs_pkg::S_BLOCK: begin
        if (core_stat.done) begin
          state_next = sha256bs_pkg::S_IDLE;
        end
      end
      sha256bs_pkg::S_PAD_A: begin
        if (core_stat.done) begin
          state_next = sha256bs_pkg::S_RESTART;
        end
      end
      sha256bs_pkg::S_RESTART: begin
        state_next = sha256bs_pkg::S_PAD_B;
      end
      sha256bs_pkg::S_PAD_B: begin
        if (core_stat.done) begin
          state_next = sha256bs_pkg::S_EMIT;
        end
      end
      sha256bs_pkg::S_EMIT: begin
        if (rsp_take && out_idx == sha256bs_pkg::LAST_WORD_IDX) begin
          state_next = sha256bs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sha256bs_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake and engine control outputs.
  always_comb begin
    req_ready      = (state == sha256bs_pkg::S_IDLE);
    rsp_valid      = (state == sha256bs_pkg::S_EMIT);
    core_ctl.start = (state == sha256bs_pkg::S_RESTART) ||
                     (state == sha256bs_pkg::S_IDLE && req_take &&
                      (req.req_type == sha256bs_pkg::REQ_FINISH ||
                       fill == sha256bs_pkg::LAST_BYTE));
  end

  // Control state, hash words and bit count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha256bs_pkg::S_IDLE;
      pad       <= sha256bs_pkg::PAD_NONE;
      hash      <= sha256bs_pkg::INITIAL_HASH;
      bit_count <= '0;
      out_idx   <= sha256bs_pkg::FIRST_WORD_IDX;
    end else begin
      state <= state_next;
      if (req_take) begin
        if (req.req_type == sha256bs_pkg::REQ_FINISH) begin
          pad <= long_pad ? sha256bs_pkg::PAD_OPEN : sha256bs_pkg::PAD_CLOSE;
        end else begin
          pad       <= sha256bs_pkg::PAD_NONE;
          bit_count <= bit_count + 64'd8;
        end
      end
      if (core_stat.done) begin
        hash <= hash_sum;
        if (state == sha256bs_pkg::S_PAD_A) begin
          pad <= sha256bs_pkg::PAD_LEN;
        end
      end
      if (rsp_take) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == sha256bs_pkg::LAST_WORD_IDX) begin
          hash      <= sha256bs_pkg::INITIAL_HASH;
          bit_count <= '0;
        end
      end
    end
  end

  // Block buffer, big-endian within each 32-bit word.
  always_ff @(posedge clk) begin
    if (req_take && req.req_type == sha256bs_pkg::REQ_APPEND) begin
      buf_words[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= req.data_byte;
    end
  end

  sha256bs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (core_ctl),
    .hash_in  (hash),
    .msg_word (msg_word),
    .stat     (core_stat),
    .hash_sum (hash_sum)
  );

  // Digest word offered from the hash registers.
  assign rsp.digest_word = hash[out_idx];
  assign rsp.word_index  = out_idx;
  assign rsp.last_word   = (out_idx == sha256bs_pkg::LAST_WORD_IDX);

endmodule

// ===== src/sha256bs_checker.sv =====
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_assert.svh"

module sha256bs_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input sha256bs_pkg::req_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input sha256bs_pkg::rsp_t rsp
);

  // No request is taken while digest words are offered.
  `SBH_ASSERT_SAME(a_no_req_in_emit, rsp_valid, !req_ready)

  // A digest always starts at the most significant word.
  `SBH_ASSERT_SAME(a_first_word, $rose(rsp_valid), rsp.word_index == sha256bs_pkg::FIRST_WORD_IDX)

  // Words follow in order without gaps until the last one.
  `SBH_ASSERT_NEXT(a_word_order, rsp_valid && rsp_ready && !rsp.last_word,
    rsp_valid && rsp.word_index == $past(rsp.word_index) + 3'd1)

  // Nothing more is offered after the last word is taken.
  `SBH_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp.last_word, !rsp_valid)

  // A finish keeps the block busy in the following cycle.
  `SBH_ASSERT_NEXT(a_finish_busy,
    req_valid && req_ready && req.req_type == sha256bs_pkg::REQ_FINISH,
    !req_ready && !rsp_valid)

endmodule

bind sha256_byte_stream_hasher sha256bs_checker u_checker (.*);

// ===== dv/tb_sha256_byte_stream_hasher.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;

  // Ways of filling a random message.
  localparam int CONTENT_RANDOM = 0;
  localparam int CONTENT_ZEROS = 1;
  localparam int CONTENT_ONES = 2;

  localparam int RANDOM_WORDS = 200;
  localparam int DRAIN_CYCLES = 140;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sha256bs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sha256bs_pkg::rsp_t rsp;

  // Predicted hasher state.
  sha256bs_pkg::hash_t running_hash;
  logic [7:0] block_bytes [64];
  logic [63:0] message_bits;
  sha256bs_pkg::rsp_t expected_digest_words [$];

  int errors = 0;
  int words_sent = 0;
  int burst_left = 0;
  bit full_rate = 1'b0;

  // Receiver stall pattern state.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  sha256_byte_stream_hasher uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of the predicted block buffer into the hash.
  function automatic void compress_block_bytes();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = running_hash;
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    running_hash[0] += a;
    running_hash[1] += b;
    running_hash[2] += c;
    running_hash[3] += d;
    running_hash[4] += e;
    running_hash[5] += f;
    running_hash[6] += g;
    running_hash[7] += h;
  endfunction

  // Applies one accepted word to the predicted state and queues any digest.
  function automatic void hash_request(input sha256bs_pkg::req_t w);
    int fill;
    int i;
    sha256bs_pkg::rsp_t r;
    fill = int'(message_bits[8:3]);
    if (w.req_type == sha256bs_pkg::REQ_APPEND) begin
      block_bytes[fill] = w.data_byte;
      message_bits += 64'd8;
      if (fill == int'(sha256bs_pkg::LAST_BYTE)) begin
        compress_block_bytes();
      end
    end else begin
      // Pad with one marker byte, zeros and the big-endian bit length.
      block_bytes[fill] = sha256bs_pkg::PAD_BYTE;
      fill++;
      if (fill > int'(sha256bs_pkg::LEN_OFFSET)) begin
        for (i = fill; i < sha256bs_pkg::BLOCK_BYTES; i++) block_bytes[i] = 8'h00;
        compress_block_bytes();
        fill = 0;
      end
      for (i = fill; i < int'(sha256bs_pkg::LEN_OFFSET); i++) block_bytes[i] = 8'h00;
      for (i = 0; i < 8; i++) begin
        block_bytes[int'(sha256bs_pkg::LEN_OFFSET) + i] = message_bits[63 - 8*i -: 8];
      end
      compress_block_bytes();
      for (i = 0; i < 8; i++) begin
        r.digest_word = running_hash[i];
        r.word_index = i[sha256bs_pkg::WORD_IDX_W-1:0];
        r.last_word = (r.word_index == sha256bs_pkg::LAST_WORD_IDX);
        expected_digest_words.push_back(r);
      end
      running_hash = sha256bs_pkg::INITIAL_HASH;
      message_bits = '0;
    end
  endfunction

  // Sends one word, with bursts and random gaps unless running at full rate.
  task automatic send_word(input sha256bs_pkg::req_t w);
    int gap;
    if (!full_rate) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
        burst_left = $urandom_range(1, 12);
        @(negedge clk);
        req_valid <= 1'b0;
        req <= sha256bs_pkg::req_t'($urandom);
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    hash_request(w);
    words_sent++;
  endtask

  // Sends a whole message of the given length, then the finish word.
  task automatic send_message(input int len, input int content);
    sha256bs_pkg::req_t w;
    int i;
    w.req_type = sha256bs_pkg::REQ_APPEND;
    for (i = 0; i < len; i++) begin
      case (content)
        CONTENT_ZEROS: w.data_byte = 8'h00;
        CONTENT_ONES: w.data_byte = 8'hff;
        default: w.data_byte = 8'($urandom_range(0, 255));
      endcase
      send_word(w);
    end
    w.req_type = sha256bs_pkg::REQ_FINISH;
    w.data_byte = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // Empty messages, with the ignored byte at both extremes.
  task automatic test_empty_message();
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_FINISH, 8'h00});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_FINISH, 8'hff});
  endtask

  // Short messages with extreme byte values and a well-known text.
  task automatic test_byte_extremes();
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'h00});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'hff});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'h80});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'h7f});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_FINISH, 8'h55});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'h61});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'h62});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_APPEND, 8'h63});
    send_word(sha256bs_pkg::req_t'{sha256bs_pkg::REQ_FINISH, 8'haa});
  endtask

  // A full block and a two-block padding case with no sender gaps.
  task automatic test_full_rate();
    full_rate = 1'b1;
    send_message(sha256bs_pkg::BLOCK_BYTES, CONTENT_RANDOM);
    send_message(int'(sha256bs_pkg::LEN_OFFSET), CONTENT_RANDOM);
    full_rate = 1'b0;
  endtask

  // Random messages, weighted toward short lengths and block boundaries.
  task automatic test_random_messages();
    int boundary_lens [11] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int start_count;
    int len;
    int content;
    int pick;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) len = $urandom_range(0, 10);
      else if (pick < 7) len = boundary_lens[$urandom_range(0, 10)];
      else len = $urandom_range(0, 130);
      pick = $urandom_range(0, 7);
      content = (pick == 0) ? CONTENT_ZEROS : (pick == 1) ? CONTENT_ONES : CONTENT_RANDOM;
      send_message(len, content);
    end
  endtask

  // Receiver: switches between always ready, light random stalls and long stalls.
  always @(negedge clk) begin
    logic ready_next;
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          ready_next = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall_left = $urandom_range(1, 20);
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
        end
      end
    endcase
    rsp_ready <= ready_next;
  end

  // Compares each accepted digest word with the oldest expected one.
  always @(posedge clk) begin
    sha256bs_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_digest_words.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, actual %h", $time, rsp);
        errors++;
      end else begin
        want = expected_digest_words.pop_front();
        if (rsp.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
                   rsp.digest_word);
          errors++;
        end
        if (rsp.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.word_index,
                   rsp.word_index);
          errors++;
        end
        if (rsp.last_word !== want.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time, want.last_word,
                   rsp.last_word);
          errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    running_hash = sha256bs_pkg::INITIAL_HASH;
    message_bits = '0;
    foreach (block_bytes[i]) block_bytes[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_byte_extremes();
    test_full_rate();
    test_random_messages();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
